/* rtl/core/msc_pkg.sv */
package msc_pkg;

	localparam int          MEM_WORDS_DEF = 4096;
	localparam logic [31:0] MEM_BASE_RST  = 32'h0040_0000;

	typedef struct packed {
		logic        req_type;
		logic [31:0] mem_addr;
		logic [31:0] mem_value;
	} req_t;

	typedef struct packed {
		logic [31:0] pc_after;
		logic [31:0] instruction;
		logic [4:0]  dest_reg;
		logic [31:0] dest_value;
		logic        halted;
		logic [31:0] executed_total;
	} rsp_t;

	typedef enum logic [1:0] {
		MD_MULT,
		MD_MULTU,
		MD_DIV,
		MD_DIVU
	} md_op_t;

	typedef struct packed {
		logic   start;
		md_op_t op;
	} md_ctl_t;

	typedef struct packed {
		logic        done;
		logic [31:0] hi;
		logic [31:0] lo;
	} md_res_t;

	// request kinds
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	// primary opcodes
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_BLEZ    = 6'h06;
	localparam logic [5:0] OP_BGTZ    = 6'h07;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_SLTI    = 6'h0A;
	localparam logic [5:0] OP_ANDI    = 6'h0C;
	localparam logic [5:0] OP_ORI     = 6'h0D;
	localparam logic [5:0] OP_XORI    = 6'h0E;
	localparam logic [5:0] OP_LUI     = 6'h0F;
	localparam logic [5:0] OP_LW      = 6'h23;

	// SPECIAL function codes
	localparam logic [5:0] FN_SLL     = 6'h00;
	localparam logic [5:0] FN_SRL     = 6'h02;
	localparam logic [5:0] FN_SRA     = 6'h03;
	localparam logic [5:0] FN_JR      = 6'h08;
	localparam logic [5:0] FN_JALR    = 6'h09;
	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [5:0] FN_MFHI    = 6'h10;
	localparam logic [5:0] FN_MTHI    = 6'h11;
	localparam logic [5:0] FN_MFLO    = 6'h12;
	localparam logic [5:0] FN_MTLO    = 6'h13;
	localparam logic [5:0] FN_MULT    = 6'h18;
	localparam logic [5:0] FN_MULTU   = 6'h19;
	localparam logic [5:0] FN_DIV     = 6'h1A;
	localparam logic [5:0] FN_DIVU    = 6'h1B;
	localparam logic [5:0] FN_ADD     = 6'h20;
	localparam logic [5:0] FN_ADDU    = 6'h21;
	localparam logic [5:0] FN_SUB     = 6'h22;
	localparam logic [5:0] FN_SUBU    = 6'h23;
	localparam logic [5:0] FN_AND     = 6'h24;
	localparam logic [5:0] FN_OR      = 6'h25;
	localparam logic [5:0] FN_XOR     = 6'h26;
	localparam logic [5:0] FN_NOR     = 6'h27;
	localparam logic [5:0] FN_SLT     = 6'h2A;

	localparam logic [4:0] REG_RA = 5'd31;

endpackage

/* rtl/core/mips_subset_core_step_unit.sv */
// MIPS32 integer-subset core, one transaction per command.
// Command channel: pulse start with req while busy is low. req_type 0
// writes one word into the local memory window, req_type 1 executes the
// instruction at the PC. Every command yields exactly one response: done
// is high for one cycle with rsp valid; the receiver cannot stall it.
// Steps from accept to done:
//   memory write, or step while halted: answered straight from idle
//   ALU, shift, jump, branch, HI/LO move: fetch read, register file
//     read, execute; next command accepted in the done cycle
//   LW: adds a second read of the word store; MULT/MULTU, DIV/DIVU wait on
//     the multiply/divide unit (bit-serial divider) unless dividing by zero
// The word store memory port and register file read latency set these.
// Reset: the word store is swept to zero, one word a cycle, all MEM_WORDS
// words; busy stays high meanwhile. Registers, HI/LO, counters clear at
// once, the PC loads mem_base. mem_base is written through the APB port
// (paddr is not decoded); the user must do so only while the core is
// idle; the block does not enforce this. The window moves, the PC does not.
module mips_subset_core_step_unit #(
	parameter int MEM_WORDS = msc_pkg::MEM_WORDS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  msc_pkg::req_t  req,
	output logic           done,
	output msc_pkg::rsp_t  rsp,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [1:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import msc_pkg::*;

	localparam int          IDX_W     = $clog2(MEM_WORDS);
	localparam logic [32:0] WIN_BYTES = 33'(MEM_WORDS) * 33'd4;

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_FETCH  = 6'b000100,
		S_READ   = 6'b001000,
		S_LWAIT  = 6'b010000,
		S_MDWAIT = 6'b100000
	} state_t;

	state_t      state_q;
	logic [31:0] base_q;
	logic [31:0] pc_q;
	logic [31:0] hi_q;
	logic [31:0] lo_q;
	logic        halt_q;
	logic [31:0] cnt_q;
	logic        done_q;
	rsp_t        rsp_q;
	logic [31:0] instr_q;
	logic [4:0]  lw_rt_q;
	logic        rd_ok_q;

	logic             accept;
	logic [31:0]      maddr;
	logic [31:0]      moff;
	logic             mok;
	logic [IDX_W-1:0] midx;
	logic             mwe;
	logic [31:0]      mrd;
	logic             clearing;
	logic [31:0]      fetched;
	logic [31:0]      lw_val;

	logic [31:0] ra;
	logic [31:0] rb;
	logic        rf_we;
	logic [4:0]  rf_waddr;
	logic [31:0] rf_wdata;

	md_ctl_t     md_ctl;
	md_res_t     md_res;

	// decoded fields of the latched instruction
	logic [5:0]  op;
	logic [5:0]  fn;
	logic [4:0]  rt;
	logic [4:0]  rd;
	logic [4:0]  sh;
	logic [15:0] imm;
	logic [31:0] simm;
	logic [31:0] pc4;

	// execute results
	logic [31:0] nxt_pc;
	logic        wr;
	logic [4:0]  tr;
	logic [31:0] tv;
	logic        wr_eff;
	logic        halt_set;
	logic        is_lw;
	logic        md_go;
	md_op_t      md_op;
	logic        set_hi;
	logic        set_lo;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// APB: one register, always ready
	assign pready = 1'b1;
	assign prdata = base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= MEM_BASE_RST;
		end else if (psel && penable && pwrite && pready) begin
			base_q <= pwdata;
		end
	end

	// one shared window check for store write, fetch and LW
	always_comb begin
		case (state_q)
			S_READ:  maddr = ra + simm;
			default: maddr = (req.req_type == REQ_STEP) ? pc_q : req.mem_addr;
		endcase
	end

	assign moff = maddr - base_q;
	assign mok  = ({1'b0, moff} < WIN_BYTES);
	assign midx = moff[IDX_W+1:2];
	assign mwe  = accept && (req.req_type == REQ_WRITE) && mok;

	msc_mem #(
		.MEM_WORDS (MEM_WORDS),
		.IDX_W     (IDX_W)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (mwe),
		.waddr    (midx),
		.wdata    (req.mem_value),
		.raddr    (midx),
		.rdata    (mrd),
		.clearing (clearing)
	);

	assign fetched = rd_ok_q ? mrd : '0;
	assign lw_val  = fetched;

	msc_regfile u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (rf_we),
		.waddr   (rf_waddr),
		.wdata   (rf_wdata),
		.raddr_a (fetched[25:21]),
		.raddr_b (fetched[20:16]),
		.rdata_a (ra),
		.rdata_b (rb)
	);

	assign md_ctl.start = (state_q == S_READ) && md_go;
	assign md_ctl.op    = md_op;

	msc_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (md_ctl),
		.a      (ra),
		.b      (rb),
		.res    (md_res)
	);

	assign op   = instr_q[31:26];
	assign rt   = instr_q[20:16];
	assign rd   = instr_q[15:11];
	assign sh   = instr_q[10:6];
	assign fn   = instr_q[5:0];
	assign imm  = instr_q[15:0];
	assign simm = {{16{imm[15]}}, imm};
	assign pc4  = pc_q + 32'd4;

	// execute stage: unlisted codes fall through as no-ops
	always_comb begin
		nxt_pc   = pc4;
		wr       = 1'b0;
		tr       = rd;
		tv       = '0;
		halt_set = 1'b0;
		is_lw    = 1'b0;
		md_go    = 1'b0;
		md_op    = MD_MULT;
		set_hi   = 1'b0;
		set_lo   = 1'b0;
		case (op)
			OP_SPECIAL: begin
				case (fn)
					FN_SYSCALL: halt_set = 1'b1;
					FN_ADD, FN_ADDU: begin
						wr = 1'b1;
						tv = ra + rb;
					end
					FN_SUB, FN_SUBU: begin
						wr = 1'b1;
						tv = ra - rb;
					end
					FN_MULT: begin
						md_go = 1'b1;
						md_op = MD_MULT;
					end
					FN_MULTU: begin
						md_go = 1'b1;
						md_op = MD_MULTU;
					end
					FN_DIV: begin
						md_go = (rb != '0);
						md_op = MD_DIV;
					end
					FN_DIVU: begin
						md_go = (rb != '0);
						md_op = MD_DIVU;
					end
					FN_AND: begin
						wr = 1'b1;
						tv = ra & rb;
					end
					FN_OR: begin
						wr = 1'b1;
						tv = ra | rb;
					end
					FN_XOR: begin
						wr = 1'b1;
						tv = ra ^ rb;
					end
					FN_NOR: begin
						wr = 1'b1;
						tv = ~(ra | rb);
					end
					FN_SLT: begin
						wr = 1'b1;
						tv = {31'd0, $signed(ra) < $signed(rb)};
					end
					FN_SLL: begin
						wr = 1'b1;
						tv = rb << sh;
					end
					FN_SRL: begin
						wr = 1'b1;
						tv = rb >> sh;
					end
					FN_SRA: begin
						wr = 1'b1;
						tv = $unsigned($signed(rb) >>> sh);
					end
					FN_JR: nxt_pc = ra;
					FN_JALR: begin
						nxt_pc = ra;
						wr     = 1'b1;
						tv     = pc4;
					end
					FN_MFHI: begin
						wr = 1'b1;
						tv = hi_q;
					end
					FN_MTHI: set_hi = 1'b1;
					FN_MFLO: begin
						wr = 1'b1;
						tv = lo_q;
					end
					FN_MTLO: set_lo = 1'b1;
					default: ;
				endcase
			end
			OP_J: nxt_pc = {pc4[31:28], instr_q[25:0], 2'b00};
			OP_JAL: begin
				nxt_pc = {pc4[31:28], instr_q[25:0], 2'b00};
				wr     = 1'b1;
				tr     = REG_RA;
				tv     = pc4;
			end
			OP_BEQ:  if (ra == rb) nxt_pc = pc4 + {simm[29:0], 2'b00};
			OP_BNE:  if (ra != rb) nxt_pc = pc4 + {simm[29:0], 2'b00};
			OP_BLEZ: if (ra == '0 || ra[31]) nxt_pc = pc4 + {simm[29:0], 2'b00};
			OP_BGTZ: if (ra != '0 && !ra[31]) nxt_pc = pc4 + {simm[29:0], 2'b00};
			OP_ADDI, OP_ADDIU: begin
				wr = 1'b1;
				tr = rt;
				tv = ra + simm;
			end
			OP_SLTI: begin
				wr = 1'b1;
				tr = rt;
				tv = {31'd0, $signed(ra) < $signed(simm)};
			end
			OP_ANDI: begin
				wr = 1'b1;
				tr = rt;
				tv = ra & {16'd0, imm};
			end
			OP_ORI: begin
				wr = 1'b1;
				tr = rt;
				tv = ra | {16'd0, imm};
			end
			OP_XORI: begin
				wr = 1'b1;
				tr = rt;
				tv = ra ^ {16'd0, imm};
			end
			OP_LUI: begin
				wr = 1'b1;
				tr = rt;
				tv = {imm, 16'd0};
			end
			OP_LW: begin
				is_lw = 1'b1;
				tr    = rt;
			end
			default: ;
		endcase
	end

	assign wr_eff = wr && (tr != '0);

	// register file write: ALU results in execute, loads in the following cycle
	always_comb begin
		rf_we    = 1'b0;
		rf_waddr = tr;
		rf_wdata = tv;
		case (state_q)
			S_READ: rf_we = wr_eff;
			S_LWAIT: begin
				rf_we    = (lw_rt_q != '0);
				rf_waddr = lw_rt_q;
				rf_wdata = lw_val;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			pc_q    <= MEM_BASE_RST;
			hi_q    <= '0;
			lo_q    <= '0;
			halt_q  <= 1'b0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			rd_ok_q <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			rd_ok_q <= mok;
			case (state_q)
				S_CLEAR: begin
					if (!clearing) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (req.req_type == REQ_WRITE || halt_q) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: state_q <= S_READ;
				S_READ: begin
					pc_q   <= nxt_pc;
					cnt_q  <= cnt_q + 32'd1;
					halt_q <= halt_q | halt_set;
					if (set_hi) begin
						hi_q <= ra;
					end
					if (set_lo) begin
						lo_q <= ra;
					end
					if (is_lw) begin
						state_q <= S_LWAIT;
					end else if (md_go) begin
						state_q <= S_MDWAIT;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_LWAIT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_MDWAIT: begin
					if (md_res.done) begin
						hi_q    <= md_res.hi;
						lo_q    <= md_res.lo;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				rsp_q.pc_after       <= pc_q;
				rsp_q.instruction    <= '0;
				rsp_q.dest_reg       <= '0;
				rsp_q.dest_value     <= '0;
				rsp_q.halted         <= halt_q;
				rsp_q.executed_total <= cnt_q;
			end
			S_FETCH: instr_q <= fetched;
			S_READ: begin
				lw_rt_q              <= rt;
				rsp_q.pc_after       <= nxt_pc;
				rsp_q.instruction    <= instr_q;
				rsp_q.dest_reg       <= wr_eff ? tr : '0;
				rsp_q.dest_value     <= wr_eff ? tv : '0;
				rsp_q.halted         <= halt_q | halt_set;
				rsp_q.executed_total <= cnt_q + 32'd1;
			end
			S_LWAIT: begin
				rsp_q.dest_reg   <= lw_rt_q;
				rsp_q.dest_value <= (lw_rt_q != '0) ? lw_val : '0;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

/* rtl/core/msc_mem.sv */
module msc_mem #(
	parameter int MEM_WORDS = msc_pkg::MEM_WORDS_DEF,
	parameter int IDX_W     = $clog2(MEM_WORDS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [31:0]      wdata,
	input  logic [IDX_W-1:0] raddr,
	output logic [31:0]      rdata,
	output logic             clearing
);
	import msc_pkg::*;

	localparam logic [IDX_W-1:0] LAST = IDX_W'(MEM_WORDS - 1);

	logic [31:0]      mem [MEM_WORDS];
	logic [IDX_W-1:0] clr_q;
	logic             clearing_q;
	logic [31:0]      rdata_q;

	// sweep zeros through the store after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			if (clr_q == LAST) begin
				clearing_q <= 1'b0;
			end
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_q] <= '0;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata    = rdata_q;
	assign clearing = clearing_q;

endmodule

/* rtl/core/msc_regfile.sv */
module msc_regfile (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        we,
	input  logic [4:0]  waddr,
	input  logic [31:0] wdata,
	input  logic [4:0]  raddr_a,
	input  logic [4:0]  raddr_b,
	output logic [31:0] rdata_a,
	output logic [31:0] rdata_b
);
	import msc_pkg::*;

	logic [31:0] mem [32];
	logic [31:0] valid_q;
	logic [31:0] ra_q;
	logic [31:0] rb_q;
	logic        va_q;
	logic        vb_q;

	// an entry never written reads as zero; $0 is never written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			va_q    <= 1'b0;
			vb_q    <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			va_q <= valid_q[raddr_a];
			vb_q <= valid_q[raddr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		ra_q <= mem[raddr_a];
		rb_q <= mem[raddr_b];
	end

	assign rdata_a = va_q ? ra_q : '0;
	assign rdata_b = vb_q ? rb_q : '0;

endmodule

/* rtl/core/msc_muldiv.sv */
module msc_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  msc_pkg::md_ctl_t  ctl,
	input  logic [31:0]       a,
	input  logic [31:0]       b,
	output msc_pkg::md_res_t  res
);
	import msc_pkg::*;

	logic               run_q;
	logic               done_q;
	logic               mul_q;
	logic [5:0]         cnt_q;
	logic signed [32:0] ma_q;
	logic signed [32:0] mb_q;
	logic [31:0]        rem_q;
	logic [31:0]        quo_q;
	logic [31:0]        dvs_q;
	logic               nq_q;
	logic               nr_q;
	logic [31:0]        hi_q;
	logic [31:0]        lo_q;
	logic               sgn;
	logic               na;
	logic               nb;
	logic signed [65:0] prod;
	logic [32:0]        trial;

	assign sgn   = (ctl.op == MD_MULT) || (ctl.op == MD_DIV);
	assign na    = sgn & a[31];
	assign nb    = sgn & b[31];
	assign prod  = ma_q * mb_q;
	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			mul_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				run_q <= 1'b1;
				mul_q <= (ctl.op == MD_MULT) || (ctl.op == MD_MULTU);
				cnt_q <= 6'd32;
			end else if (run_q) begin
				if (mul_q || cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// restoring divide, one quotient bit a cycle, sign fixup at the end
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			ma_q  <= {na, a};
			mb_q  <= {nb, b};
			rem_q <= '0;
			quo_q <= na ? (32'd0 - a) : a;
			dvs_q <= nb ? (32'd0 - b) : b;
			nq_q  <= na ^ nb;
			nr_q  <= na;
		end else if (run_q) begin
			if (mul_q) begin
				hi_q <= prod[63:32];
				lo_q <= prod[31:0];
			end else if (cnt_q != '0) begin
				if (!trial[32]) begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= {rem_q[30:0], quo_q[31]};
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end else begin
				lo_q <= nq_q ? (32'd0 - quo_q) : quo_q;
				hi_q <= nr_q ? (32'd0 - rem_q) : rem_q;
			end
		end
	end

	assign res.done = done_q;
	assign res.hi   = hi_q;
	assign res.lo   = lo_q;

endmodule

/* rtl/core/msc_checker.sv */
module msc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input msc_pkg::req_t req,
	input logic          done,
	input msc_pkg::rsp_t rsp
);
	import msc_pkg::*;

	// an accepted command either answers at once or keeps the core busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted command neither busy nor answered");

	// a response always comes with the core idle and ready for the next command
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("response while the core is busy");

	// an answer in the cycle after acceptance executes nothing
	a_quick_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && !busy) |-> rsp.instruction == '0 && rsp.dest_reg == '0)
		else $error("immediate response carries an instruction");

	// meant for busy up to the answer; vacuous, as busy is in the antecedent
	a_busy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !done && $past(busy) |-> !start || busy)
		else $error("busy dropped without a response");

endmodule

bind mips_subset_core_step_unit msc_checker u_msc_checker (.*);
